// ===== design/sha_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 package
// Round constants, initial hash values and shared command/status types.
// ----------------------------------------------------------------------------
package sha_pkg;

	localparam logic [1:0] KIND_BYTE   = 2'd0;
	localparam logic [1:0] KIND_FINAL  = 2'd1;
	localparam logic [1:0] KIND_END    = 2'd2;
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	// Byte source selection for the block buffer.
	localparam logic [1:0] SRC_DATA = 2'd0;
	localparam logic [1:0] SRC_PAD  = 2'd1;
	localparam logic [1:0] SRC_ZERO = 2'd2;
	localparam logic [1:0] SRC_LEN  = 2'd3;

	localparam logic [5:0] LEN_POS = 6'd56;

	typedef struct packed {
		logic       push;       // write one byte into the block buffer
		logic [1:0] src;
		logic [7:0] data;
		logic       add_bits;   // count eight message bits
		logic       load;       // start compression: load working regs
		logic       round;      // one compression round
		logic       fold;       // add working regs into the hash words
		logic       restart;    // back to initial hash values
		logic       shift_out;  // rotate hash words for output
		logic       latch_len;  // capture bit count for padding
	} sha_cmd_t;

	typedef struct packed {
		logic [5:0] fill;
		logic       rounds_done;
	} sha_stat_t;

	function automatic logic [31:0] round_k(input logic [5:0] r);
		logic [31:0] k [64];
		k = '{
			32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
			32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
			32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
			32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
			32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
			32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
			32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
			32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
			32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
			32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
			32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
			32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
			32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
			32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
			32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
			32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
		return k[r];
	endfunction

	function automatic logic [31:0] init_hash(input logic [2:0] i);
		logic [31:0] h [8];
		h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
			32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
		return h[i];
	endfunction

endpackage
`default_nettype wire

// ===== design/sha_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 datapath
// Block buffer, bit counter, message schedule and one-round-per-cycle core.
// ----------------------------------------------------------------------------
module sha_datapath (
	input  wire               clk,
	input  wire               arst_n,
	input  sha_pkg::sha_cmd_t cmd,
	output sha_pkg::sha_stat_t stat,
	output logic [31:0]       digest_word
);
	import sha_pkg::*;

	// The block is held as sixteen big-endian words, filled one byte at a time.
	logic [31:0] block_q [16];
	logic [31:0] sched_q [16];
	logic [31:0] hash_q [8];
	logic [31:0] work_q [8];
	logic [5:0]  fill_q;
	logic [5:0]  rnd_q;
	logic        busy_q;
	logic [63:0] bits_q;
	logic [63:0] len_q;
	logic [7:0]  byte_d;
	logic [31:0] w, x15, x2, g0, g1, t1, t2, e, a;
	logic [3:0]  slot;

	always_comb begin
		case (cmd.src)
			SRC_DATA: byte_d = cmd.data;
			SRC_PAD:  byte_d = 8'h80;
			SRC_ZERO: byte_d = 8'h00;
			default:  byte_d = len_q[63 - {fill_q[2:0], 3'd0} -: 8];
		endcase
	end

	// The first sixteen rounds read the block; later ones extend the schedule.
	always_comb begin
		slot = rnd_q[3:0];
		x15  = sched_q[slot + 4'd1];
		x2   = sched_q[slot + 4'd14];
		g0   = {x15[6:0], x15[31:7]} ^ {x15[17:0], x15[31:18]} ^ (x15 >> 3);
		g1   = {x2[16:0], x2[31:17]} ^ {x2[18:0], x2[31:19]} ^ (x2 >> 10);
		if (rnd_q < 6'd16)
			w = block_q[slot];
		else
			w = sched_q[slot] + g0 + sched_q[slot + 4'd9] + g1;
		e  = work_q[4];
		a  = work_q[0];
		t1 = work_q[7] + ({e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]})
			+ ((e & work_q[5]) ^ (~e & work_q[6])) + round_k(rnd_q) + w;
		t2 = ({a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]})
			+ ((a & work_q[1]) ^ (a & work_q[2]) ^ (work_q[1] & work_q[2]));
	end

	always_ff @(posedge clk) begin
		if (cmd.push)
			block_q[fill_q[5:2]][{~fill_q[1:0], 3'd0} +: 8] <= byte_d;
		if (cmd.round && busy_q) begin
			sched_q[slot] <= w;
			work_q[7] <= work_q[6];
			work_q[6] <= work_q[5];
			work_q[5] <= work_q[4];
			work_q[4] <= work_q[3] + t1;
			work_q[3] <= work_q[2];
			work_q[2] <= work_q[1];
			work_q[1] <= work_q[0];
			work_q[0] <= t1 + t2;
		end else if (cmd.load) begin
			for (int i = 0; i < 8; i++)
				work_q[i] <= hash_q[i];
		end
		if (cmd.latch_len)
			len_q <= bits_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			rnd_q  <= '0;
			busy_q <= 1'b0;
			bits_q <= '0;
			for (int i = 0; i < 8; i++)
				hash_q[i] <= init_hash(3'(i));
		end else begin
			if (cmd.push)
				fill_q <= fill_q + 6'd1;
			if (cmd.add_bits)
				bits_q <= bits_q + 64'd8;
			if (cmd.load) begin
				busy_q <= 1'b1;
				rnd_q  <= '0;
			end else if (cmd.round && busy_q) begin
				rnd_q <= rnd_q + 6'd1;
				if (rnd_q == 6'd63)
					busy_q <= 1'b0;
			end
			if (cmd.fold) begin
				for (int i = 0; i < 8; i++)
					hash_q[i] <= hash_q[i] + work_q[i];
			end else if (cmd.restart) begin
				bits_q <= '0;
				fill_q <= '0;
				for (int i = 0; i < 8; i++)
					hash_q[i] <= init_hash(3'(i));
			end else if (cmd.shift_out) begin
				for (int i = 0; i < 7; i++)
					hash_q[i] <= hash_q[i + 1];
				hash_q[7] <= hash_q[0];
			end
		end
	end

	assign stat.fill        = fill_q;
	assign stat.rounds_done = !busy_q;
	assign digest_word      = hash_q[0];

endmodule
`default_nettype wire

// ===== design/sha_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 controller
// Sequences byte intake, padding, compression and digest output.
// ----------------------------------------------------------------------------
module sha_ctrl (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_stall,
	input  wire  [1:0]         kind,
	input  wire  [7:0]         data_byte,
	output logic               out_valid,
	input  wire                out_stall,
	output logic [2:0]         word_index,
	output logic               last_word,
	output sha_pkg::sha_cmd_t  cmd,
	input  sha_pkg::sha_stat_t stat
);
	import sha_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_COMP = 3'd1;
	localparam logic [2:0] ST_FOLD = 3'd2;
	localparam logic [2:0] ST_PAD  = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	// Padding phases.
	localparam logic [1:0] PAD_NONE = 2'd0;
	localparam logic [1:0] PAD_MARK = 2'd1;  // 0x80 still to be written
	localparam logic [1:0] PAD_LEN  = 2'd2;  // zeros, then length in this block
	localparam logic [1:0] PAD_ZERO = 2'd3;  // zeros to block end, length block follows

	logic [2:0] state_q, state_d;
	logic [1:0] pad_q, pad_d;
	logic       fin_q, fin_d;    // padding in progress for this transaction
	logic [2:0] idx_q, idx_d;
	logic       take;

	assign in_stall   = (state_q != ST_IDLE);
	assign take       = in_valid && !in_stall;
	assign out_valid  = (state_q == ST_OUT);
	assign word_index = idx_q;
	assign last_word  = (idx_q == 3'd7);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		pad_d   = pad_q;
		fin_d   = fin_q;
		idx_d   = idx_q;
		unique case (state_q)
			ST_IDLE: begin
				if (take && kind != KIND_UNUSED) begin
					cmd.src  = SRC_DATA;
					cmd.data = data_byte;
					if (kind != KIND_END) begin
						cmd.push     = 1'b1;
						cmd.add_bits = 1'b1;
					end
					if (kind != KIND_BYTE) begin
						fin_d   = 1'b1;
						pad_d   = PAD_MARK;
						state_d = ST_PAD;
					end
					if (kind != KIND_END && stat.fill == 6'd63) begin
						cmd.load = 1'b1;
						state_d  = ST_COMP;
					end
				end
			end
			ST_PAD: begin
				cmd.push = 1'b1;
				if (pad_q == PAD_MARK) begin
					// Bit count is final once the last byte has been counted.
					cmd.latch_len = 1'b1;
					cmd.src = SRC_PAD;
					// The eight length bytes fit only if the marker lands before them.
					pad_d   = (stat.fill < LEN_POS) ? PAD_LEN : PAD_ZERO;
				end else if (pad_q == PAD_LEN && stat.fill >= LEN_POS)
					cmd.src = SRC_LEN;
				else
					cmd.src = SRC_ZERO;
				if (stat.fill == 6'd63) begin
					cmd.load = 1'b1;
					state_d  = ST_COMP;
				end
			end
			ST_COMP: begin
				cmd.round = 1'b1;
				if (stat.rounds_done)
					state_d = ST_FOLD;
			end
			ST_FOLD: begin
				cmd.fold = 1'b1;
				if (!fin_q)
					state_d = ST_IDLE;
				else if (pad_q == PAD_LEN) begin
					state_d = ST_OUT;
					idx_d   = '0;
				end else begin
					// The block filled before the length went in; pad the next one.
					if (pad_q == PAD_ZERO)
						pad_d = PAD_LEN;
					state_d = ST_PAD;
				end
			end
			ST_OUT: begin
				if (!out_stall) begin
					cmd.shift_out = 1'b1;
					idx_d = idx_q + 3'd1;
					if (idx_q == 3'd7) begin
						cmd.shift_out = 1'b0;
						cmd.restart   = 1'b1;
						fin_d   = 1'b0;
						pad_d   = PAD_NONE;
						idx_d   = '0;
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pad_q   <= PAD_NONE;
			fin_q   <= 1'b0;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			pad_q   <= pad_d;
			fin_q   <= fin_d;
			idx_q   <= idx_d;
		end
	end

endmodule
`default_nettype wire

// ===== design/sha256_stream_hasher.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Hashes a byte stream and emits the eight digest words per message.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake          | Payload
// input   | in        | in_valid/in_stall  | kind, data_byte
// output  | out       | out_valid/out_stall| digest_word, word_index, last_word
//
// An ordinary byte does not stall the input; the 64th byte of a block starts
// the 64 compression rounds, one per cycle in a single round unit.
// A final transaction pads one byte per cycle, compresses once or twice,
// then presents eight words, one per cycle when the output is not stalled.
// Reset restores the initial hash values and clears the byte and bit counts.
// in_stall is high from the cycle after an accepted block-ending byte until
// the block is folded, and during padding and output.
module sha256_stream_hasher (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [1:0]  kind,
	input  wire  [7:0]  data_byte,
	output logic        out_valid,
	input  wire         out_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);
	import sha_pkg::*;

	sha_cmd_t  cmd;
	sha_stat_t stat;

	sha_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .data_byte(data_byte),
		.out_valid(out_valid), .out_stall(out_stall),
		.word_index(word_index), .last_word(last_word),
		.cmd(cmd), .stat(stat)
	);

	sha_datapath u_dp (
		.clk(clk), .arst_n(arst_n),
		.cmd(cmd), .stat(stat), .digest_word(digest_word)
	);

	a_no_accept_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input accepted during output");
	a_last_is_seven: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last_word) |-> (word_index == 3'd7)) else $error("bad last word");
	a_idx_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !last_word) |=> (out_valid
		&& word_index == $past(word_index) + 3'd1)) else $error("word order broken");

endmodule
`default_nettype wire

// ===== verif/sha256_stream_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 stream checker
// Watches both channels of the hasher, keeps its own SHA-256 state, and
// compares each digest word against the oldest expected word.
// ----------------------------------------------------------------------------
module sha256_stream_checker (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	input  wire         in_stall,
	input  wire  [1:0]  kind,
	input  wire  [7:0]  data_byte,
	input  wire         out_valid,
	input  wire         out_stall,
	input  wire  [31:0] digest_word,
	input  wire  [2:0]  word_index,
	input  wire         last_word,
	output int          fail_count,
	output int          words_pending
);
	import sha_pkg::*;

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  index;
		logic        last;
	} digest_item_t;

	logic [31:0]  hash_state [8];
	logic [7:0]   block_bytes [64];
	int           fill;
	logic [63:0]  msg_bits;
	digest_item_t digest_queue [$];

	function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
		return (v >> n) | (v << (32 - n));
	endfunction

	task automatic compress_block();
		logic [31:0] w [64];
		logic [31:0] s [8];
		logic [31:0] t1, t2;
		for (int r = 0; r < 16; r++)
			w[r] = {block_bytes[4*r], block_bytes[4*r+1], block_bytes[4*r+2],
				block_bytes[4*r+3]};
		for (int r = 16; r < 64; r++)
			w[r] = w[r-16] + w[r-7]
				+ (rotr(w[r-15], 7) ^ rotr(w[r-15], 18) ^ (w[r-15] >> 3))
				+ (rotr(w[r-2], 17) ^ rotr(w[r-2], 19) ^ (w[r-2] >> 10));
		s = hash_state;
		for (int r = 0; r < 64; r++) begin
			t1 = s[7] + (rotr(s[4], 6) ^ rotr(s[4], 11) ^ rotr(s[4], 25))
				+ ((s[4] & s[5]) ^ (~s[4] & s[6])) + round_k(r[5:0]) + w[r];
			t2 = (rotr(s[0], 2) ^ rotr(s[0], 13) ^ rotr(s[0], 22))
				+ ((s[0] & s[1]) ^ (s[0] & s[2]) ^ (s[1] & s[2]));
			s[7] = s[6]; s[6] = s[5]; s[5] = s[4]; s[4] = s[3] + t1;
			s[3] = s[2]; s[2] = s[1]; s[1] = s[0]; s[0] = t1 + t2;
		end
		for (int j = 0; j < 8; j++)
			hash_state[j] = hash_state[j] + s[j];
	endtask

	task automatic add_byte(input logic [7:0] b);
		block_bytes[fill] = b;
		fill++;
		if (fill == 64) begin
			compress_block();
			fill = 0;
		end
	endtask

	task automatic start_message();
		for (int j = 0; j < 8; j++)
			hash_state[j] = init_hash(j[2:0]);
		fill = 0;
		msg_bits = '0;
	endtask

	// Runs one accepted input transaction through the digest model.
	task automatic hash_transaction(input logic [1:0] k, input logic [7:0] b);
		logic [63:0] total;
		if (k != KIND_BYTE && k != KIND_FINAL && k != KIND_END)
			return;
		if (k != KIND_END) begin
			msg_bits += 64'd8;
			add_byte(b);
			if (k == KIND_BYTE)
				return;
		end
		total = msg_bits;
		add_byte(8'h80);
		while (fill != LEN_POS)
			add_byte(8'h00);
		for (int i = 0; i < 8; i++)
			add_byte(total[63 - 8*i -: 8]);
		for (int i = 0; i < 8; i++)
			digest_queue.push_back('{hash_state[i], i[2:0], i == 7});
		start_message();
	endtask

	always @(posedge clk or negedge arst_n) begin
		digest_item_t exp_item;
		if (!arst_n) begin
			start_message();
			digest_queue.delete();
			fail_count = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (digest_queue.size() == 0) begin
					$display("%0t: unexpected digest word %h", $time, digest_word);
					fail_count++;
				end else begin
					exp_item = digest_queue.pop_front();
					if (digest_word !== exp_item.word) begin
						$display("%0t: digest_word expected %h actual %h", $time,
							exp_item.word, digest_word);
						fail_count++;
					end
					if (word_index !== exp_item.index) begin
						$display("%0t: word_index expected %0d actual %0d", $time,
							exp_item.index, word_index);
						fail_count++;
					end
					if (last_word !== exp_item.last) begin
						$display("%0t: last_word expected %0d actual %0d", $time,
							exp_item.last, last_word);
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall)
				hash_transaction(kind, data_byte);
		end
		words_pending = digest_queue.size();
	end
endmodule

// ===== verif/sha256_stream_hasher_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 stream hasher testbench
// Feeds messages of many lengths with random gaps and output stalls; the
// checker predicts every digest word and counts mismatches.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_tb;
	import sha_pkg::*;

	localparam int IDLE_LIMIT = 20000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  kind;
	logic [7:0]  data_byte;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;
	int          fail_count;
	int          words_pending;
	int          idle_cycles;
	logic        calm;

	sha256_stream_hasher u_top (.*);

	sha256_stream_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Output stalls, except during the calm stretch.
	always @(negedge clk)
		out_stall <= !calm && ($urandom_range(99) < 21);

	// A cycle with no transaction on either side counts toward the timeout.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Returns at the falling edge after acceptance with valid still high; the
	// next call or the caller sets valid for the following cycle.
	task automatic send(input logic [1:0] k, input logic [7:0] b);
		while (!calm && $urandom_range(99) < 21) begin
			in_valid <= 1'b0;
			kind <= 2'($urandom);
			data_byte <= 8'($urandom);
			@(negedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		data_byte <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	// A message of n random bytes, ended either by a final byte or an end item.
	task automatic send_message(input int n, input bit with_final);
		for (int i = 0; i < n; i++)
			send((with_final && i == n - 1) ? KIND_FINAL : KIND_BYTE, 8'($urandom));
		if (!with_final || n == 0)
			send(KIND_END, 8'($urandom));
	endtask

	initial begin
		int n;
		calm = 1'b0;
		idle_cycles = 0;
		in_valid = 1'b0;
		kind = KIND_BYTE;
		data_byte = 8'h00;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: empty message, unused kind, extreme bytes, short messages.
		send(KIND_END, 8'hff);
		send(KIND_UNUSED, 8'hff);
		send(KIND_FINAL, 8'h00);
		send(KIND_BYTE, 8'hff);
		send(KIND_UNUSED, 8'h00);
		send(KIND_FINAL, 8'hff);
		send(KIND_BYTE, 8'h55);
		send(KIND_END, 8'haa);
		send_message(1, 0);
		send_message(3, 1);
		send_message(2, 0);

		// Random: message lengths around the block and padding boundaries.
		n = 0;
		while (n < 410) begin
			int len;
			calm = (n > 150 && n < 230);
			case ($urandom_range(4))
				0: len = $urandom_range(54, 57);
				1: len = $urandom_range(62, 66);
				2: len = $urandom_range(118, 121);
				default: len = $urandom_range(0, 12);
			endcase
			if ($urandom_range(9) == 0)
				send(KIND_UNUSED, 8'($urandom));
			send_message(len, $urandom_range(1));
			n += len + 1;
		end
		in_valid <= 1'b0;
		calm = 1'b0;

		while (words_pending != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule

// ===== files.f =====
design/sha_pkg.sv
design/sha_datapath.sv
design/sha_ctrl.sv
design/sha256_stream_hasher.sv
verif/sha256_stream_checker.sv
verif/sha256_stream_hasher_tb.sv
